>>> rtl/mmie_pkg.sv
`timescale 1ns / 1ps
package mmie_pkg;

   localparam int ADDR_BITS_DEFAULT = 16;

   typedef enum logic [4:0] {
      OP_NOP     = 5'd0,
      OP_ADD     = 5'd1,
      OP_ADD_W   = 5'd2,
      OP_SUB     = 5'd3,
      OP_SUB_W   = 5'd4,
      OP_MUL     = 5'd5,
      OP_MUL_W   = 5'd6,
      OP_DIV     = 5'd7,
      OP_DIV_W   = 5'd8,
      OP_NOT     = 5'd9,
      OP_LSHIFT  = 5'd10,
      OP_RSHIFT  = 5'd11,
      OP_AND     = 5'd12,
      OP_OR      = 5'd13,
      OP_XOR     = 5'd14,
      OP_JUMP_V  = 5'd15,
      OP_JUMP    = 5'd16,
      OP_CJUMP   = 5'd17,
      OP_CJUMP_W = 5'd18,
      OP_CMP     = 5'd19,
      OP_CMP_W   = 5'd20,
      OP_SET_V   = 5'd21,
      OP_SET_VW  = 5'd22,
      OP_COPY    = 5'd23,
      OP_COPY_W  = 5'd24,
      OP_GET     = 5'd25,
      OP_GET_W   = 5'd26,
      OP_SET     = 5'd27,
      OP_SET_W   = 5'd28
   } opcode_type;

   // alu operation selected by the sequencer
   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_MUL, ALU_NOT, ALU_SHL, ALU_SHR,
      ALU_AND, ALU_OR, ALU_XOR, ALU_PASS_A
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_RD_A0, ST_RD_A1, ST_RD_B0, ST_RD_B1,
      ST_RD_P0, ST_RD_P1, ST_RD_D0, ST_RD_D1,
      ST_EXEC, ST_DIV, ST_WR0, ST_WR1, ST_DONE
   } state_type;

   localparam logic [7:0] CMP_TRUE = 8'h01;
   localparam logic [7:0] CMP_ZERO = 8'h00;

   function automatic logic is_wide(input logic [4:0] op);
      case (op)
         OP_ADD_W, OP_SUB_W, OP_MUL_W, OP_DIV_W, OP_JUMP, OP_CJUMP_W,
         OP_CMP_W, OP_SET_VW, OP_COPY_W, OP_GET_W, OP_SET_W: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic reads_b(input logic [4:0] op);
      case (op)
         OP_ADD, OP_ADD_W, OP_SUB, OP_SUB_W, OP_MUL, OP_MUL_W, OP_DIV, OP_DIV_W,
         OP_LSHIFT, OP_RSHIFT, OP_AND, OP_OR, OP_XOR, OP_CJUMP, OP_CJUMP_W,
         OP_CMP, OP_CMP_W: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic reads_a(input logic [4:0] op);
      case (op)
         OP_NOP, OP_JUMP_V, OP_SET_V, OP_SET_VW: return 1'b0;
         default: return (op <= OP_SET_W);
      endcase
   endfunction

endpackage

>>> rtl/mmie_alu.sv
`timescale 1ns / 1ps
module mmie_alu (
   input  mmie_pkg::alu_op_type alu_op,
   input  logic [15:0]          opnd_a,
   input  logic [15:0]          opnd_b,
   output logic [15:0]          result,
   output logic                 a_gt_b,
   output logic                 a_eq_b
);
   import mmie_pkg::*;

   logic [31:0] product;

   assign product = 32'(opnd_a) * 32'(opnd_b);
   assign a_gt_b  = opnd_a > opnd_b;
   assign a_eq_b  = opnd_a == opnd_b;

   always_comb begin
      result = 16'h0000;
      case (alu_op)
         ALU_ADD:    result = opnd_a + opnd_b;
         ALU_SUB:    result = opnd_a - opnd_b;
         ALU_MUL:    result = product[15:0];
         ALU_NOT:    result = {8'h00, ~opnd_a[7:0]};
         ALU_SHL:    result = (opnd_b[7:3] != 5'd0) ? 16'h0000
                              : {8'h00, opnd_a[7:0] << opnd_b[2:0]};
         ALU_SHR:    result = (opnd_b[7:3] != 5'd0) ? 16'h0000
                              : {8'h00, opnd_a[7:0] >> opnd_b[2:0]};
         ALU_AND:    result = opnd_a & opnd_b;
         ALU_OR:     result = opnd_a | opnd_b;
         ALU_XOR:    result = opnd_a ^ opnd_b;
         ALU_PASS_A: result = opnd_a;
         default:    result = 16'h0000;
      endcase
   end
endmodule

>>> rtl/mmie_divider.sv
`timescale 1ns / 1ps
module mmie_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   logic [15:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] trial;

   // one quotient bit a cycle, restoring
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[15:0], quo_ff[15]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = 17'd0;
         dvs_in  = divisor;
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            rem_in = trial;
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[15]};
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= 5'd0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

>>> rtl/mmie_data_ram.sv
`timescale 1ns / 1ps
module mmie_data_ram #(
   parameter int ADDR_BITS = mmie_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [7:0]           wr_data,
   output logic [7:0]           rd_data
);
   logic [7:0] mem [2**ADDR_BITS];
   logic [7:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_ff <= mem[addr];
   end

   assign rd_data = rd_ff;
endmodule

>>> rtl/memory_to_memory_instruction_executor.sv
`timescale 1ns / 1ps
// Executes one decoded instruction against a single-port byte data memory and
// returns the next pc and a divide-by-zero flag. After reset a clearing pass
// writes zero to every byte, one per cycle, with req_tready low. Each byte
// read from the memory is an address step and then a registered read. The
// longest items are the word operations that read four bytes and write two,
// and div_w, which also runs the bit-serial divider. A result that waits on
// rsp_tready holds the block in its last state with req_tready low. One item
// is worked on at a time.
module memory_to_memory_instruction_executor #(
   parameter int ADDR_BITS = mmie_pkg::ADDR_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[4:0], src_a_addr[20:5], src_b_addr[36:21], dest_addr[52:37],
   // immediate[68:53], next_pc[84:69], zero fill
   input  logic [87:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pc[15:0], div_by_zero[16], zero fill
   output logic [23:0]  rsp_tdata
);
   import mmie_pkg::*;

   localparam logic [ADDR_BITS:0] MEM_DEPTH = (ADDR_BITS + 1)'(2**ADDR_BITS);

   state_type state_ff, state_in;

   logic [4:0]  op_ff, op_in;
   logic [15:0] a_addr_ff, a_addr_in, b_addr_ff, b_addr_in, d_addr_ff, d_addr_in;
   logic [15:0] imm_ff, imm_in, pc_ff, pc_in;
   logic [15:0] a_val_ff, a_val_in, b_val_ff, b_val_in, ptr_ff, ptr_in;
   logic [15:0] res_ff, res_in;
   logic [ADDR_BITS-1:0] wr_addr_ff, wr_addr_in;
   logic        write_en_ff, write_en_in;
   logic        dz_ff, dz_in;
   logic        pend_ff, pend_in;     // read issued last cycle, data now valid
   logic [ADDR_BITS:0] clr_ff, clr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_pc_ff, rsp_pc_in;
   logic        rsp_dz_ff, rsp_dz_in;

   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_addr;
   logic [7:0]           ram_wdata, ram_rdata;

   alu_op_type  alu_op;
   logic [15:0] alu_res;
   logic        alu_gt, alu_eq;
   logic        div_start, div_busy;
   logic [15:0] div_quo;
   logic        wide;

   assign wide = is_wide(op_ff);

   mmie_data_ram #(.ADDR_BITS(ADDR_BITS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   mmie_alu u_alu (
      .alu_op (alu_op),
      .opnd_a (a_val_ff),
      .opnd_b (b_val_ff),
      .result (alu_res),
      .a_gt_b (alu_gt),
      .a_eq_b (alu_eq)
   );

   mmie_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_val_ff),
      .divisor  (b_val_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_comb begin
      alu_op = ALU_PASS_A;
      case (op_ff)
         OP_ADD, OP_ADD_W: alu_op = ALU_ADD;
         OP_SUB, OP_SUB_W: alu_op = ALU_SUB;
         OP_MUL, OP_MUL_W: alu_op = ALU_MUL;
         OP_NOT:           alu_op = ALU_NOT;
         OP_LSHIFT:        alu_op = ALU_SHL;
         OP_RSHIFT:        alu_op = ALU_SHR;
         OP_AND:           alu_op = ALU_AND;
         OP_OR:            alu_op = ALU_OR;
         OP_XOR:           alu_op = ALU_XOR;
         default:          alu_op = ALU_PASS_A;
      endcase
   end

   // next state and datapath registers
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      a_addr_in   = a_addr_ff;
      b_addr_in   = b_addr_ff;
      d_addr_in   = d_addr_ff;
      imm_in      = imm_ff;
      pc_in       = pc_ff;
      a_val_in    = a_val_ff;
      b_val_in    = b_val_ff;
      ptr_in      = ptr_ff;
      res_in      = res_ff;
      wr_addr_in  = wr_addr_ff;
      write_en_in = write_en_ff;
      dz_in       = dz_ff;
      pend_in     = 1'b0;
      clr_in      = clr_ff;
      div_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_pc_in   = rsp_pc_ff;
      rsp_dz_in   = rsp_dz_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MEM_DEPTH - 1'b1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in       = req_tdata[4:0];
               a_addr_in   = req_tdata[20:5];
               b_addr_in   = req_tdata[36:21];
               d_addr_in   = req_tdata[52:37];
               imm_in      = req_tdata[68:53];
               pc_in       = req_tdata[84:69];
               a_val_in    = 16'h0000;
               b_val_in    = 16'h0000;
               dz_in       = 1'b0;
               write_en_in = 1'b0;
               if (reads_a(req_tdata[4:0])) state_in = ST_RD_A0;
               else state_in = ST_EXEC;
            end
         end
         ST_RD_A0: begin
            if (pend_ff) begin
               a_val_in = {8'h00, ram_rdata};
               // get always needs the whole pointer word
               if (wide || op_ff == OP_GET) state_in = ST_RD_A1;
               else if (reads_b(op_ff)) state_in = ST_RD_B0;
               else if (op_ff == OP_SET) state_in = ST_RD_D0;
               else state_in = ST_EXEC;
            end else pend_in = 1'b1;
         end
         ST_RD_A1: begin
            if (pend_ff) begin
               a_val_in = {ram_rdata, a_val_ff[7:0]};
               if (reads_b(op_ff)) state_in = ST_RD_B0;
               else if (op_ff == OP_GET || op_ff == OP_GET_W) state_in = ST_RD_P0;
               else if (op_ff == OP_SET_W) state_in = ST_RD_D0;
               else state_in = ST_EXEC;
            end else pend_in = 1'b1;
         end
         ST_RD_B0: begin
            if (pend_ff) begin
               b_val_in = {8'h00, ram_rdata};
               state_in = wide ? ST_RD_B1 : ST_EXEC;
            end else pend_in = 1'b1;
         end
         ST_RD_B1: begin
            if (pend_ff) begin
               b_val_in = {ram_rdata, b_val_ff[7:0]};
               state_in = ST_EXEC;
            end else pend_in = 1'b1;
         end
         // get: a_val holds the pointer, fetch the byte(s) it points at
         ST_RD_P0: begin
            if (pend_ff) begin
               ptr_in   = a_val_ff;
               a_val_in = {8'h00, ram_rdata};
               state_in = wide ? ST_RD_P1 : ST_EXEC;
            end else pend_in = 1'b1;
         end
         ST_RD_P1: begin
            if (pend_ff) begin
               a_val_in = {ram_rdata, a_val_ff[7:0]};
               state_in = ST_EXEC;
            end else pend_in = 1'b1;
         end
         // set: fetch the target pointer word at dest_addr
         ST_RD_D0: begin
            if (pend_ff) begin
               ptr_in   = {8'h00, ram_rdata};
               state_in = ST_RD_D1;
            end else pend_in = 1'b1;
         end
         ST_RD_D1: begin
            if (pend_ff) begin
               ptr_in   = {ram_rdata, ptr_ff[7:0]};
               d_addr_in = {ram_rdata, ptr_ff[7:0]};
               state_in = ST_EXEC;
            end else pend_in = 1'b1;
         end
         ST_EXEC: begin
            wr_addr_in  = ADDR_BITS'(d_addr_ff);
            res_in      = alu_res;
            write_en_in = 1'b1;
            state_in    = ST_WR0;
            case (op_ff)
               OP_NOP, OP_JUMP_V, OP_JUMP, OP_CJUMP, OP_CJUMP_W: begin
                  write_en_in = 1'b0;
                  if (op_ff == OP_JUMP_V) pc_in = imm_ff;
                  else if (op_ff == OP_JUMP) pc_in = a_val_ff;
                  else if ((op_ff == OP_CJUMP || op_ff == OP_CJUMP_W) && alu_gt)
                     pc_in = imm_ff;
                  state_in = ST_DONE;
               end
               OP_DIV, OP_DIV_W: begin
                  if (b_val_ff == 16'h0000) begin
                     res_in = 16'hFFFF;
                     dz_in  = 1'b1;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               OP_CMP, OP_CMP_W: begin
                  res_in      = {8'h00, CMP_TRUE};
                  write_en_in = alu_eq;
                  state_in    = alu_eq ? ST_WR0 : ST_DONE;
               end
               OP_SET_V, OP_SET_VW: res_in = imm_ff;
               default: begin
                  if (op_ff > OP_SET_W) begin
                     write_en_in = 1'b0;
                     state_in    = ST_DONE;
                  end
               end
            endcase
         end
         ST_DIV: begin
            if (!div_busy && !div_start) begin
               res_in   = div_quo;
               state_in = ST_WR0;
            end
         end
         ST_WR0: begin
            state_in = (wide && op_ff != OP_CMP_W) ? ST_WR1 : ST_DONE;
         end
         ST_WR1: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pc_in    = pc_ff;
               rsp_dz_in    = dz_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory port drive
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = ADDR_BITS'(a_addr_ff);
      ram_wdata = res_ff[7:0];
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff[ADDR_BITS-1:0];
            ram_wdata = CMP_ZERO;
         end
         ST_RD_A0: ram_addr = ADDR_BITS'(a_addr_ff);
         ST_RD_A1: ram_addr = ADDR_BITS'(a_addr_ff) + 1'b1;
         ST_RD_B0: ram_addr = ADDR_BITS'(b_addr_ff);
         ST_RD_B1: ram_addr = ADDR_BITS'(b_addr_ff) + 1'b1;
         ST_RD_P0: ram_addr = ADDR_BITS'(a_val_ff);
         ST_RD_P1: ram_addr = ADDR_BITS'(ptr_ff) + 1'b1;
         ST_RD_D0: ram_addr = ADDR_BITS'(d_addr_ff);
         ST_RD_D1: ram_addr = ADDR_BITS'(d_addr_ff) + 1'b1;
         ST_WR0: begin
            ram_we   = write_en_ff;
            ram_addr = wr_addr_ff;
         end
         ST_WR1: begin
            ram_we    = write_en_ff;
            ram_addr  = wr_addr_ff + 1'b1;
            ram_wdata = res_ff[15:8];
         end
         default: ram_addr = ADDR_BITS'(a_addr_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_addr_ff   <= a_addr_in;
      b_addr_ff   <= b_addr_in;
      d_addr_ff   <= d_addr_in;
      imm_ff      <= imm_in;
      pc_ff       <= pc_in;
      a_val_ff    <= a_val_in;
      b_val_ff    <= b_val_in;
      ptr_ff      <= ptr_in;
      res_ff      <= res_in;
      wr_addr_ff  <= wr_addr_in;
      dz_ff       <= dz_in;
      rsp_pc_ff   <= rsp_pc_in;
      rsp_dz_ff   <= rsp_dz_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         write_en_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         write_en_ff  <= write_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_dz_ff, rsp_pc_ff};

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_we)
      else $error("memory written while idle");

   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && dz_ff) |-> (op_ff == OP_DIV || op_ff == OP_DIV_W))
      else $error("divide by zero flag on non-divide");

   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_tvalid)
      else $error("item finished without result");
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import mmie_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int MEM_DEPTH = 65536;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // opcode, src_a_addr, src_b_addr, dest_addr, immediate, next_pc, zero fill
   logic [87:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // new_pc, div_by_zero, zero fill
   logic [23:0] rsp_tdata;

   logic [7:0] shadow_mem [0:MEM_DEPTH-1];
   logic [16:0] pending_results [$];
   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic hold_rsp = 1'b0;

   memory_to_memory_instruction_executor uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [7:0] rd8(logic [15:0] addr);
      return shadow_mem[addr];
   endfunction

   function automatic logic [15:0] rd16(logic [15:0] addr);
      return {shadow_mem[addr + 16'd1], shadow_mem[addr]};
   endfunction

   function automatic void wr8(logic [15:0] addr, logic [7:0] value);
      shadow_mem[addr] = value;
   endfunction

   function automatic void wr16(logic [15:0] addr, logic [15:0] value);
      shadow_mem[addr] = value[7:0];
      shadow_mem[addr + 16'd1] = value[15:8];
   endfunction

   // returns {div_by_zero, new_pc} and updates the shadow memory
   function automatic logic [16:0] execute_instr(logic [4:0] op, logic [15:0] a,
         logic [15:0] b, logic [15:0] d, logic [15:0] imm, logic [15:0] pc);
      logic dz;
      logic [7:0] x8, y8;
      logic [15:0] x16, y16;
      logic [31:0] prod;
      dz = 1'b0;
      x8 = rd8(a);
      y8 = rd8(b);
      x16 = rd16(a);
      y16 = rd16(b);
      case (op)
         OP_ADD: wr8(d, x8 + y8);
         OP_ADD_W: wr16(d, x16 + y16);
         OP_SUB: wr8(d, x8 - y8);
         OP_SUB_W: wr16(d, x16 - y16);
         OP_MUL: wr8(d, x8 * y8);
         OP_MUL_W: begin
            prod = x16 * y16;
            wr16(d, prod[15:0]);
         end
         OP_DIV: begin
            if (y8 == 8'd0) begin
               wr8(d, 8'hFF);
               dz = 1'b1;
            end else begin
               wr8(d, x8 / y8);
            end
         end
         OP_DIV_W: begin
            if (y16 == 16'd0) begin
               wr16(d, 16'hFFFF);
               dz = 1'b1;
            end else begin
               wr16(d, x16 / y16);
            end
         end
         OP_NOT: wr8(d, ~x8);
         OP_LSHIFT: wr8(d, (y8 >= 8) ? 8'd0 : 8'(x8 << y8));
         OP_RSHIFT: wr8(d, (y8 >= 8) ? 8'd0 : 8'(x8 >> y8));
         OP_AND: wr8(d, x8 & y8);
         OP_OR: wr8(d, x8 | y8);
         OP_XOR: wr8(d, x8 ^ y8);
         OP_JUMP_V: pc = imm;
         OP_JUMP: pc = x16;
         OP_CJUMP: if (x8 > y8) pc = imm;
         OP_CJUMP_W: if (x16 > y16) pc = imm;
         OP_CMP: if (x8 == y8) wr8(d, CMP_TRUE);
         OP_CMP_W: if (x16 == y16) wr8(d, CMP_TRUE);
         OP_SET_V: wr8(d, imm[7:0]);
         OP_SET_VW: wr16(d, imm);
         OP_COPY: wr8(d, x8);
         OP_COPY_W: wr16(d, x16);
         OP_GET: wr8(d, rd8(x16));
         OP_GET_W: wr16(d, rd16(x16));
         OP_SET: wr8(rd16(d), x8);
         OP_SET_W: wr16(rd16(d), x16);
         default: ;
      endcase
      return {dz, pc};
   endfunction

   always @(posedge clock) begin
      logic [16:0] want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: new_pc=%h div_by_zero=%b",
                        rsp_tdata[15:0], rsp_tdata[16]);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[15:0] !== want[15:0] || rsp_tdata[16] !== want[16]) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: new_pc exp %h got %h, div_by_zero exp %b got %b",
                           want[15:0], rsp_tdata[15:0], want[16], rsp_tdata[16]);
            end
         end
      end
   end

   task automatic send_instr(logic [4:0] op, logic [15:0] a, logic [15:0] b,
         logic [15:0] d, logic [15:0] imm, logic [15:0] pc);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      pending_results.push_back(execute_instr(op, a, b, d, imm, pc));
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, pc, imm, d, b, a, op};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [15:0] pick_addr();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 16'($urandom_range(31));
      if (r < 80) return 16'($urandom_range(16'hFFFF, 16'hFFF0));
      return 16'($urandom);
   endfunction

   task automatic send_random();
      logic [4:0] op;
      logic [15:0] imm;
      int r;
      r = $urandom_range(99);
      if (r < 4) op = 5'($urandom_range(31, 29));
      else if (r < 25) op = ($urandom_range(1)) ? OP_SET_V : OP_SET_VW;
      else op = 5'($urandom_range(28));
      imm = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(9));
      send_instr(op, pick_addr(), pick_addr(), pick_addr(), imm, 16'($urandom));
   endtask

   task automatic test_directed();
      send_instr(OP_SET_V, 0, 0, 16'h10, 16'hAAFF, 16'h0001);
      send_instr(OP_SET_V, 0, 0, 16'h11, 16'h0001, 16'hFFFF);
      send_instr(OP_SET_VW, 0, 0, 16'h20, 16'h1234, 16'h0002);
      // word straddling the top address
      send_instr(OP_SET_VW, 0, 0, 16'hFFFF, 16'hABCD, 16'h0003);
      send_instr(OP_ADD, 16'h10, 16'h11, 16'h12, 0, 16'h0004);
      send_instr(OP_ADD_W, 16'hFFFF, 16'h20, 16'h22, 0, 16'h0005);
      send_instr(OP_SUB, 16'h11, 16'h10, 16'h13, 0, 16'h0006);
      send_instr(OP_SUB_W, 16'h30, 16'h20, 16'h24, 0, 16'h0007);
      send_instr(OP_MUL, 16'h10, 16'h10, 16'h14, 0, 16'h0008);
      send_instr(OP_MUL_W, 16'h20, 16'hFFFF, 16'h26, 0, 16'h0009);
      send_instr(OP_DIV, 16'h10, 16'h30, 16'h15, 0, 16'h000A);
      send_instr(OP_DIV_W, 16'h20, 16'h30, 16'h28, 0, 16'h000B);
      send_instr(OP_DIV_W, 16'h22, 16'h20, 16'h2A, 0, 16'h000C);
      send_instr(OP_NOT, 16'h10, 0, 16'h16, 0, 16'h000D);
      send_instr(OP_SET_V, 0, 0, 16'h31, 16'h0008, 16'h000E);
      send_instr(OP_LSHIFT, 16'h10, 16'h31, 16'h17, 0, 16'h000F);
      send_instr(OP_RSHIFT, 16'h10, 16'h11, 16'h18, 0, 16'h0010);
      send_instr(OP_AND, 16'h10, 16'h20, 16'h19, 0, 16'h0011);
      send_instr(OP_OR, 16'h11, 16'h20, 16'h1A, 0, 16'h0012);
      send_instr(OP_XOR, 16'h10, 16'h21, 16'h1B, 0, 16'h0013);
      send_instr(OP_JUMP_V, 0, 0, 0, 16'hBEEF, 16'h0014);
      send_instr(OP_JUMP, 16'h20, 0, 0, 0, 16'h0015);
      send_instr(OP_CJUMP, 16'h10, 16'h11, 0, 16'h4000, 16'h0016);
      send_instr(OP_CJUMP_W, 16'h30, 16'h20, 0, 16'h5000, 16'h0017);
      send_instr(OP_CMP, 16'h10, 16'h10, 16'h40, 0, 16'h0018);
      // unequal words, so no result byte is written
      send_instr(OP_CMP_W, 16'h30, 16'h32, 16'h41, 0, 16'h0019);
      send_instr(OP_CMP, 16'h10, 16'h11, 16'h42, 0, 16'h001A);
      send_instr(OP_COPY, 16'h10, 0, 16'h43, 0, 16'h001B);
      send_instr(OP_COPY_W, 16'hFFFF, 0, 16'h44, 0, 16'h001C);
      send_instr(OP_SET_VW, 0, 0, 16'h50, 16'h0010, 16'h001D);
      send_instr(OP_GET, 16'h50, 0, 16'h52, 0, 16'h001E);
      send_instr(OP_GET_W, 16'h50, 0, 16'h54, 0, 16'h001F);
      send_instr(OP_SET, 16'h11, 0, 16'h50, 0, 16'h0020);
      send_instr(OP_SET_W, 16'h20, 0, 16'h50, 0, 16'h0021);
      send_instr(OP_NOP, 16'h10, 16'h11, 16'h12, 16'h1111, 16'h0022);
      send_instr(5'd31, 16'h10, 16'h11, 16'h12, 16'h2222, 16'h0023);
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_random();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         repeat (20) send_random();
      join
   endtask

   initial begin
      foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(100, 0, 0);
      test_random(100, 82, 0);
      test_random(100, 0, 82);
      test_random(100, 11, 11);
      test_backpressure();
      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
